>>> rtl/core/uve_pkg.sv
// ----------------------------------------------------------------------------
// uve_pkg: shared types and helpers for the UTF-8 validate and escape block
// Beat structures for both channels, the sequence classifier and the hex
// digit encoder used when a lead byte is escaped.
// ----------------------------------------------------------------------------
package uve_pkg;

  // One input beat: a raw byte and the end-of-string marker.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } uve_in_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;
    logic       stream_valid;
  } uve_out_t;

  // Verdict on the bytes at the front of the window.
  typedef struct packed {
    logic       fail;
    logic       pend;
    logic [2:0] len;
  } uve_cls_t;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X      = 8'h78;

  // Up to four window bytes, byte 0 first; n is the number present (1..4).
  function automatic uve_cls_t classify(input logic [3:0][7:0] w, input logic [2:0] n);
    uve_cls_t   c;
    logic [7:0] lead;
    logic [7:0] b;
    logic [2:0] len;
    logic       ok;
    logic       bad;
    c    = '0;
    lead = w[0];
    bad  = 1'b0;
    len  = 3'd0;
    if (lead <= 8'h7F) begin
      len = 3'd1;
    end else if (lead >= 8'hC2 && lead <= 8'hDF) begin
      len = 3'd2;
    end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
      len = 3'd3;
    end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
      len = 3'd4;
    end else begin
      bad = 1'b1;
    end
    for (int k = 1; k < 4; k++) begin
      b = w[k];
      if (k == 1 && lead == 8'hE0) begin
        ok = (b >= 8'hA0 && b <= 8'hBF);
      end else if (k == 1 && lead == 8'hED) begin
        ok = (b >= 8'h80 && b <= 8'h9F);
      end else if (k == 1 && lead == 8'hF0) begin
        ok = (b >= 8'h90 && b <= 8'hBF);
      end else if (k == 1 && lead == 8'hF4) begin
        ok = (b >= 8'h80 && b <= 8'h8F);
      end else begin
        ok = ((b & 8'hC0) == 8'h80);
      end
      if (!bad && 3'(k) < len && 3'(k) < n && !ok) begin
        bad = 1'b1;
      end
    end
    c.fail = bad;
    c.pend = !bad && (n < len);
    c.len  = len;
    return c;
  endfunction

  // Uppercase hex character for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/utf8_validate_escape.sv
// The first beat caused by a byte goes through the CLASS state, PASS or ESC and
// the pending slot into the output register; held bytes of an open sequence
// wait for its verdict. A byte holds the block in CLASS, PASS and ESC through
// the shared classifier, so no new byte is taken until the sequencer is idle.
// Reset (rst_n low, synchronous) empties the window, the output register and
// the escape flag; bytes held from an unfinished sequence are dropped.
// ----------------------------------------------------------------------------
// utf8_validate_escape: streaming strict UTF-8 checker with lead escaping
// Bytes of valid sequences pass through; the lead of a broken or cut-off
// sequence becomes a backslash, an x and two uppercase hex digits.
// ----------------------------------------------------------------------------
module utf8_validate_escape (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  uve_pkg::uve_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output uve_pkg::uve_out_t out_data
);

  // Sequencer states. IDLE is the only state that takes an input beat.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLASS = 2'd1;
  localparam logic [1:0] S_PASS  = 2'd2;
  localparam logic [1:0] S_ESC   = 2'd3;

  localparam logic [1:0] ESC_LAST = 2'd3;

  logic [1:0]       state_r, state_nxt;
  // The window holds the undecided bytes, oldest in byte 0. Consumed bytes
  // are shifted out so the classifier always looks at the front.
  logic [3:0][7:0]  win_r, win_nxt;
  logic [2:0]       cnt_r, cnt_nxt;      // bytes in the window, 0 to 4
  logic             last_r, last_nxt;    // current byte closes the string
  logic [2:0]       run_r, run_nxt;      // bytes of a valid sequence still to pass
  logic [1:0]       idx_r, idx_nxt;      // which escape character is next
  logic             esc_seen_r, esc_seen_nxt;

  // The newest generated character waits here one step, so that it can be
  // flagged as the end of its run once the sequencer knows nothing follows.
  logic [7:0]       pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;

  logic             out_valid_r;
  uve_pkg::uve_out_t out_data_r;

  logic             out_free;
  logic             push;
  uve_pkg::uve_out_t push_data;
  logic             gen;
  logic [7:0]       gen_byte;
  uve_pkg::uve_cls_t cls;

  // The shared classifier: one instance serves every decision of the step.
  assign cls = uve_pkg::classify(win_r, cnt_r);

  assign out_free = !out_valid_r || !out_stall;

  // Character produced in PASS or ESC this cycle, if the sequencer moves.
  always_comb begin
    gen_byte = win_r[0];
    if (state_r == S_ESC) begin
      case (idx_r)
        2'd0:    gen_byte = uve_pkg::CHAR_BSLASH;
        2'd1:    gen_byte = uve_pkg::CHAR_X;
        2'd2:    gen_byte = uve_pkg::hex_char(win_r[0][7:4]);
        default: gen_byte = uve_pkg::hex_char(win_r[0][3:0]);
      endcase
    end
  end

  // A new character may enter the pending slot when the slot is empty or
  // its old content can move into the output register.
  assign gen = (state_r == S_PASS || state_r == S_ESC) && (!pend_v_r || out_free);

  always_comb begin
    state_nxt    = state_r;
    win_nxt      = win_r;
    cnt_nxt      = cnt_r;
    last_nxt     = last_r;
    run_nxt      = run_r;
    idx_nxt      = idx_r;
    esc_seen_nxt = esc_seen_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    push         = 1'b0;
    push_data    = '0;

    if (gen) begin
      // Earlier character is not the last of this run.
      push                = pend_v_r;
      push_data.out_byte  = pend_r;
      pend_nxt            = gen_byte;
      pend_v_nxt          = 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          win_nxt[cnt_r[1:0]] = in_data.in_byte;
          cnt_nxt             = cnt_r + 3'd1;
          last_nxt            = in_data.in_last;
          state_nxt           = S_CLASS;
        end
      end
      S_CLASS: begin
        if (cnt_r == 3'd0 || (cls.pend && !last_r)) begin
          // Nothing more comes from this byte: close the run.
          if (!pend_v_r) begin
            state_nxt = S_IDLE;
          end else if (out_free) begin
            push                   = 1'b1;
            push_data.out_byte     = pend_r;
            push_data.run_end      = 1'b1;
            push_data.stream_end   = last_r;
            push_data.stream_valid = last_r && !esc_seen_r;
            pend_v_nxt             = 1'b0;
            state_nxt              = S_IDLE;
            if (last_r) begin
              esc_seen_nxt = 1'b0;
              cnt_nxt      = 3'd0;
            end
          end
        end else if (cls.fail || cls.pend) begin
          // Broken sequence, or one cut off by the end of the string.
          idx_nxt   = 2'd0;
          state_nxt = S_ESC;
        end else begin
          run_nxt   = cls.len;
          state_nxt = S_PASS;
        end
      end
      S_PASS: begin
        if (gen) begin
          win_nxt = win_r >> 8;
          cnt_nxt = cnt_r - 3'd1;
          run_nxt = run_r - 3'd1;
          if (run_r == 3'd1) begin
            state_nxt = S_CLASS;
          end
        end
      end
      S_ESC: begin
        if (gen) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == ESC_LAST) begin
            // Only the lead goes; the bytes behind it are scanned again.
            win_nxt      = win_r >> 8;
            cnt_nxt      = cnt_r - 3'd1;
            esc_seen_nxt = 1'b1;
            state_nxt    = S_CLASS;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 3'd0;
      last_r      <= 1'b0;
      run_r       <= 3'd0;
      idx_r       <= 2'd0;
      esc_seen_r  <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      last_r     <= last_nxt;
      run_r      <= run_nxt;
      idx_r      <= idx_nxt;
      esc_seen_r <= esc_seen_nxt;
      pend_v_r   <= pend_v_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    pend_r <= pend_nxt;
    if (push) begin
      out_data_r <= push_data;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The pending slot is always drained before the next byte is taken.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("character left pending between input beats");

  // At most three bytes stay held between input beats.
  a_idle_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r <= 3'd3))
    else $error("window overfull while idle");

  // Closing a string clears the escape flag and the window.
  a_stream_close: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_data.stream_end) |=> (!esc_seen_r && cnt_r == 3'd0))
    else $error("string state not cleared at stream end");

  // The validity flag only ever appears on the closing beat.
  a_valid_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.stream_valid || out_data_r.stream_end))
    else $error("stream_valid raised away from stream end");

endmodule

>>> tb/utf8_validate_escape_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_validate_escape_tb: self-checking bench for the UTF-8 validate/escape block
// Drives byte streams through the valid/stall input channel and checks every
// output beat against a directed table or an in-bench scanner that tracks held
// bytes and the per-stream escape flag. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module utf8_validate_escape_tb;

  localparam int        RAND_ITEMS   = 144;
  localparam int        IDLE_LIMIT   = 2000;
  localparam int        DRAIN_CYCLES = 40;
  localparam int        UNTYPED      = -1;
  localparam int        SEQ_BROKEN   = -1;
  localparam int        SEQ_OPEN     = 0;
  localparam logic [7:0] BACKSLASH   = 8'h5C;
  localparam logic [7:0] LETTER_X    = 8'h78;

  // One row of the directed table. n_out of UNTYPED means the row is checked
  // against the scanner; otherwise chars holds the expected bytes, first one
  // in the top byte, and ok the expected stream verdict when last is set.
  typedef struct {
    logic [7:0]  b;
    bit          last;
    int          n_out;
    logic [31:0] chars;
    bit          ok;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  uve_pkg::uve_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  uve_pkg::uve_out_t out_data;

  // Scanner state: bytes of an undecided sequence and the escape flag.
  logic [7:0] held [3];
  int         held_n = 0;
  bit         esc_flag = 1'b0;
  logic [7:0] win [4];

  uve_pkg::uve_out_t scan_out[$];
  uve_pkg::uve_out_t chars_due[$];
  dir_row_t          dir_rows[$];
  logic [7:0]        rand_bytes[$];
  logic [7:0]        seq[$];

  int errors      = 0;
  int idle_cycles = 0;
  int out_wait    = 0;
  bit in_calm     = 1'b0;
  bit out_calm    = 1'b0;

  utf8_validate_escape u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Judges the n bytes of the window starting at index at: returns the length
  // of a complete valid sequence, SEQ_OPEN for a valid but unfinished prefix,
  // or SEQ_BROKEN.
  function automatic int seq_verdict(input int at, input int n);
    logic [7:0] lead;
    logic [7:0] b;
    int         len;
    bit         ok;
    lead = win[at];
    if (lead <= 8'h7F) return 1;
    if (lead >= 8'hC2 && lead <= 8'hDF) len = 2;
    else if (lead >= 8'hE0 && lead <= 8'hEF) len = 3;
    else if (lead >= 8'hF0 && lead <= 8'hF4) len = 4;
    else return SEQ_BROKEN;
    for (int k = 1; k < len && k < n; k++) begin
      b = win[at + k];
      // The second byte has a narrower range after E0, ED, F0 and F4, which
      // rules out overlongs, surrogates and code points above U+10FFFF.
      if (k == 1 && lead == 8'hE0) ok = (b >= 8'hA0 && b <= 8'hBF);
      else if (k == 1 && lead == 8'hED) ok = (b >= 8'h80 && b <= 8'h9F);
      else if (k == 1 && lead == 8'hF0) ok = (b >= 8'h90 && b <= 8'hBF);
      else if (k == 1 && lead == 8'hF4) ok = (b >= 8'h80 && b <= 8'h8F);
      else ok = (b[7:6] == 2'b10);
      if (!ok) return SEQ_BROKEN;
    end
    return (n >= len) ? len : SEQ_OPEN;
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? 8'("0") + 8'(v) : 8'("A") + 8'(v) - 8'd10;
  endfunction

  function automatic void push_char(input logic [7:0] c);
    uve_pkg::uve_out_t beat;
    beat          = '0;
    beat.out_byte = c;
    scan_out.insert(scan_out.size(), beat);
  endfunction

  // Feeds one input byte to the scanner and leaves the beats it causes in
  // scan_out. Held bytes are rescanned from the byte after an escaped lead.
  function automatic void scan_byte(input logic [7:0] b, input bit last);
    int n;
    int pos;
    int r;
    scan_out.delete();
    for (int i = 0; i < held_n; i++) win[i] = held[i];
    win[held_n] = b;
    n   = held_n + 1;
    pos = 0;
    while (pos < n) begin
      r = seq_verdict(pos, n - pos);
      if (r > 0) begin
        for (int i = 0; i < r; i++) push_char(win[pos + i]);
        pos += r;
      end else if (r == SEQ_OPEN && !last) begin
        break;
      end else begin
        push_char(BACKSLASH);
        push_char(LETTER_X);
        push_char(nibble_char(win[pos][7:4]));
        push_char(nibble_char(win[pos][3:0]));
        esc_flag = 1'b1;
        pos++;
      end
    end
    held_n = n - pos;
    for (int i = 0; i < held_n; i++) held[i] = win[pos + i];
    if (scan_out.size() > 0) begin
      scan_out[$].run_end = 1'b1;
      if (last) begin
        scan_out[$].stream_end   = 1'b1;
        scan_out[$].stream_valid = !esc_flag;
      end
    end
    if (last) begin
      esc_flag = 1'b0;
      held_n   = 0;
    end
  endfunction

  task automatic add_row(input logic [7:0] b, input bit last, input int n_out,
                         input logic [31:0] chars, input bit ok);
    dir_row_t row;
    row.b     = b;
    row.last  = last;
    row.n_out = n_out;
    row.chars = chars;
    row.ok    = ok;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Offers one beat after a random gap, waits for it to be taken, then runs
  // the scanner on it. valid is only lowered when a gap is actually drawn.
  task automatic send_beat(input logic [7:0] b, input bit last);
    int gap;
    if ($urandom_range(0, 24) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data.in_byte <= b;
    in_data.in_last <= last;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    scan_byte(b, last);
  endtask

  // Output side: checks each accepted beat against the oldest expectation and
  // draws a random stall, which may be empty, after every beat taken.
  always @(posedge clk) begin : out_side
    int w;
    uve_pkg::uve_out_t want;
    if (!rst_n) begin
      out_stall   <= 1'b0;
      out_wait    <= 0;
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (chars_due.size() == 0) begin
          $display("%0t: unexpected out beat: got byte %h run_end %b stream_end %b valid %b",
                   $time, out_data.out_byte, out_data.run_end, out_data.stream_end,
                   out_data.stream_valid);
          errors++;
        end else begin
          want = chars_due.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.run_end !== want.run_end ||
              out_data.stream_end !== want.stream_end ||
              out_data.stream_valid !== want.stream_valid) begin
            $display("%0t: out beat mismatch: expected byte %h run_end %b stream_end %b valid %b",
                     $time, want.out_byte, want.run_end, want.stream_end, want.stream_valid);
            $display("%0t:                    actual   byte %h run_end %b stream_end %b valid %b",
                     $time, out_data.out_byte, out_data.run_end, out_data.stream_end,
                     out_data.stream_valid);
            errors++;
          end
        end
        if ($urandom_range(0, 24) == 0) out_calm = !out_calm;
        w = out_calm ? 0 : $urandom_range(0, 4);
        out_wait  <= w;
        out_stall <= (w != 0);
      end else if (out_wait > 1) begin
        out_wait <= out_wait - 1;
      end else begin
        out_wait  <= 0;
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("utf8_validate_escape: mismatch");
    $finish;
  end

  initial begin
    uve_pkg::uve_out_t beat;
    int                kind;
    int                len;
    int                cut;
    logic [7:0]        lead;
    logic [7:0]        lo;
    logic [7:0]        hi;
    bit                last;

    // Directed table: stream extremes, bad leads, every special second-byte
    // range and a follow byte that breaks an open sequence at the end of a
    // stream (the last row produces the most beats per byte).
    add_row(8'h00, 1'b1, 1, 32'h0000_0000, 1'b1);
    add_row(8'h80, 1'b1, 4, "\\x80", 1'b0);
    add_row(8'hFF, 1'b1, 4, "\\xFF", 1'b0);
    add_row(8'hC1, 1'b0, 4, "\\xC1", 1'b0);
    add_row(8'h41, 1'b1, 1, {"A", 24'h0}, 1'b0);
    add_row(8'hC2, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'h80, 1'b1, UNTYPED, '0, 1'b0);
    add_row(8'hE0, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'hA0, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'h80, 1'b1, UNTYPED, '0, 1'b0);
    add_row(8'hED, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'hA0, 1'b1, UNTYPED, '0, 1'b0);
    add_row(8'hF0, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'h90, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'h80, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'hBF, 1'b1, UNTYPED, '0, 1'b0);
    add_row(8'hF4, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'h8F, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'hBF, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'hBF, 1'b1, UNTYPED, '0, 1'b0);
    add_row(8'hF4, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'h90, 1'b1, UNTYPED, '0, 1'b0);
    add_row(8'hF1, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'h80, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'h80, 1'b0, UNTYPED, '0, 1'b0);
    add_row(8'hFF, 1'b1, UNTYPED, '0, 1'b0);

    // Random bytes: mostly well-formed sequences with random content, the
    // rest noise, sequences with one byte overwritten and truncated ones.
    while (rand_bytes.size() < RAND_ITEMS) begin
      kind = $urandom_range(0, 99);
      seq.delete();
      if (kind < 20) begin
        seq.insert(seq.size(), 8'($urandom_range(0, 8'h7F)));
      end else if (kind < 30) begin
        seq.insert(seq.size(), 8'($urandom_range(0, 8'hFF)));
      end else begin
        len = $urandom_range(2, 4);
        case (len)
          2: begin
            lead = 8'($urandom_range(8'hC2, 8'hDF));
          end
          3: begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
          end
          default: begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
          end
        endcase
        seq.insert(seq.size(), lead);
        for (int k = 1; k < len; k++) begin
          lo = 8'h80;
          hi = 8'hBF;
          if (k == 1 && lead == 8'hE0) lo = 8'hA0;
          if (k == 1 && lead == 8'hED) hi = 8'h9F;
          if (k == 1 && lead == 8'hF0) lo = 8'h90;
          if (k == 1 && lead == 8'hF4) hi = 8'h8F;
          seq.insert(seq.size(), 8'($urandom_range(lo, hi)));
        end
        if (kind >= 75 && kind < 88) begin
          seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 8'hFF));
        end else if (kind >= 88) begin
          cut = $urandom_range(1, len - 1);
          repeat (cut) seq.delete(seq.size() - 1);
        end
      end
      foreach (seq[i]) rand_bytes.insert(rand_bytes.size(), seq[i]);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].b, dir_rows[i].last);
      if (dir_rows[i].n_out == UNTYPED) begin
        foreach (scan_out[j]) chars_due.insert(chars_due.size(), scan_out[j]);
      end else begin
        for (int k = 0; k < dir_rows[i].n_out; k++) begin
          beat          = '0;
          beat.out_byte = dir_rows[i].chars[31 - 8 * k -: 8];
          if (k == dir_rows[i].n_out - 1) begin
            beat.run_end      = 1'b1;
            beat.stream_end   = dir_rows[i].last;
            beat.stream_valid = dir_rows[i].last && dir_rows[i].ok;
          end
          chars_due.insert(chars_due.size(), beat);
        end
      end
    end

    // Streams end at random points; the very last byte closes the final one
    // so that nothing is left held when the run drains.
    foreach (rand_bytes[i]) begin
      last = ($urandom_range(0, 7) == 0) || (i == rand_bytes.size() - 1);
      send_beat(rand_bytes[i], last);
      foreach (scan_out[j]) chars_due.insert(chars_due.size(), scan_out[j]);
    end
    in_valid <= 1'b0;

    while (chars_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("utf8_validate_escape: match");
    end else begin
      $display("utf8_validate_escape: mismatch");
    end
    $finish;
  end

endmodule
